[rtl/pas_pkg.sv]
// ----------------------------------------------------------------------------
// pas_pkg: shared types and constants of the priority aging scheduler
// Field widths of one job slot and the token that walks the cell chain.
// ----------------------------------------------------------------------------
package pas_pkg;

    localparam int unsigned TimeW  = 32;
    localparam int unsigned ArrW   = 16;
    localparam int unsigned BurstW = 16;
    localparam int unsigned PrioW  = 8;
    localparam int unsigned SlotW  = 4;
    localparam logic [15:0] AgingReset = 16'd5;
    localparam logic [31:0] TimeMax    = 32'hFFFF_FFFF;

    localparam logic FuncLoad = 1'b0;
    localparam logic FuncTick = 1'b1;

    // best-candidate token passed from cell to cell during the pick pass
    typedef struct packed {
        logic              found;
        logic [PrioW-1:0]  prio;
        logic [ArrW-1:0]   arr;
        logic [SlotW-1:0]  slot;
    } t_best;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PICK,
        ST_AGE,
        ST_OUT
    } t_state;

endpackage

[rtl/priority_aging_scheduler.sv]
// ----------------------------------------------------------------------------
// priority_aging_scheduler: preemptive priority scheduler with aging
// A chain of slot cells; a tick walks a best-job token through the chain.
// ----------------------------------------------------------------------------
//  channel | handshake         | payload
//  in      | i_valid / o_stall | i_func i_slot i_arrival_time i_burst_length
//          |                   | i_base_priority
//  out     | o_valid / i_stall | o_tick_time .. o_all_done
//  cfg     | i_cfg_valid/o_cfg_ready | i_cfg_data (aging_interval)
//
//  A load writes its slot cell directly. A tick runs mark, the token walk
//  through the cells one by one, the aging/run step, then the result register.
//  Reset is synchronous; no clearing pass. A stalled result holds the block.
module priority_aging_scheduler
    import pas_pkg::*;
#(
    parameter int unsigned SLOTS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_func,
    input  logic [SlotW-1:0]  i_slot,
    input  logic [ArrW-1:0]   i_arrival_time,
    input  logic [BurstW-1:0] i_burst_length,
    input  logic [PrioW-1:0]  i_base_priority,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [15:0]       i_cfg_data,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [TimeW-1:0]  o_tick_time,
    output logic [SlotW-1:0]  o_running_slot,
    output logic              o_cpu_idle,
    output logic              o_job_finished,
    output logic [TimeW-1:0]  o_turnaround,
    output logic [TimeW-1:0]  o_waiting,
    output logic              o_all_done
);

    localparam int unsigned NC = (SLOTS > 16) ? 16 : SLOTS;
    localparam int unsigned CW = $clog2(NC + 1);

    t_state           r_state, n_state;
    logic [CW-1:0]    r_cnt;
    logic [15:0]      r_interval;
    logic [TimeW-1:0] r_now;
    t_best            r_tok;
    logic             r_ovalid;
    t_best            tok_in  [NC];
    t_best            tok_out [NC];
    logic [NC-1:0]    fin, pend;
    logic [BurstW-1:0] burst_v [NC];
    logic [ArrW-1:0]   arr_v   [NC];
    logic             acc, load;
    logic [15:0]      interval;
    logic [TimeW-1:0] now_inc, tat;
    logic [BurstW-1:0] b_burst;
    logic [ArrW-1:0]   b_arr;
    logic             b_fin;

    assign acc      = i_valid && !o_stall;
    assign o_stall  = (r_state != ST_IDLE);
    assign load     = acc && (i_func == FuncLoad) && ({28'd0, i_slot} < 32'(NC));
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign interval = (r_interval == '0) ? 16'd1 : r_interval;
    assign now_inc  = (r_now == TimeMax) ? r_now : r_now + 32'd1;

    // cells; all see the running token, each updates it only on its own turn in the pick pass
    for (genvar g = 0; g < NC; g++) begin : g_cell
        assign tok_in[g] = r_tok;
        pas_cell #(.ID(SlotW'(g))) u_cell (
            .i_clk, .i_rst_n,
            .i_load     (load && i_slot == SlotW'(g)),
            .i_arr      (i_arrival_time),
            .i_burst    (i_burst_length),
            .i_prio     (i_base_priority),
            .i_mark     (r_state == ST_IDLE && acc && i_func == FuncTick),
            .i_pick     (r_state == ST_PICK && r_cnt == CW'(g)),
            .i_age      (r_state == ST_AGE && r_tok.found),
            .i_now      (r_now),
            .i_interval (interval),
            .i_best_slot(r_tok.slot),
            .i_tok      (tok_in[g]),
            .o_tok      (tok_out[g]),
            .o_finish   (fin[g]),
            .o_burst    (burst_v[g]),
            .o_arr      (arr_v[g]),
            .o_pending  (pend[g])
        );
    end

    assign b_burst = burst_v[r_tok.slot[$clog2(NC)-1:0]];
    assign b_arr   = arr_v[r_tok.slot[$clog2(NC)-1:0]];
    assign b_fin   = r_tok.found && fin[r_tok.slot[$clog2(NC)-1:0]];
    assign tat     = now_inc - {16'd0, b_arr};

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (acc && i_func == FuncTick) n_state = ST_PICK;
            ST_PICK: if (r_cnt == CW'(NC - 1)) n_state = ST_AGE;
            ST_AGE:  n_state = ST_OUT;
            ST_OUT:  if (!i_stall) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cnt      <= '0;
            r_interval <= AgingReset;
            r_now      <= '0;
            r_tok      <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) r_interval <= i_cfg_data;
            case (r_state)
                ST_IDLE: begin
                    r_cnt <= '0;
                    r_tok <= '0;
                end
                ST_PICK: begin
                    r_tok <= tok_out[r_cnt[$clog2(NC)-1:0]];
                    r_cnt <= r_cnt + CW'(1);
                end
                ST_AGE: begin
                    r_ovalid <= 1'b1;
                    r_now    <= now_inc;
                end
                ST_OUT: if (!i_stall) r_ovalid <= 1'b0;
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (r_state == ST_AGE) begin
            o_tick_time    <= r_now;
            o_running_slot <= r_tok.found ? r_tok.slot : '0;
            o_cpu_idle     <= !r_tok.found;
            o_job_finished <= b_fin;
            o_turnaround   <= b_fin ? tat : '0;
            o_waiting      <= (b_fin && tat >= {16'd0, b_burst}) ? tat - {16'd0, b_burst} : '0;
            o_all_done     <= ((pend & ~(NC'(b_fin) << r_tok.slot)) == '0);
        end
    end

    assign o_valid = r_ovalid;

endmodule

[rtl/pas_cell.sv]
// ----------------------------------------------------------------------------
// pas_cell: one job slot of the scheduler chain
// Holds the slot state and compares itself against the token passing by.
// ----------------------------------------------------------------------------
module pas_cell
    import pas_pkg::*;
#(
    parameter logic [SlotW-1:0] ID = '0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // load port
    input  logic              i_load,
    input  logic [ArrW-1:0]   i_arr,
    input  logic [BurstW-1:0] i_burst,
    input  logic [PrioW-1:0]  i_prio,
    // tick control
    input  logic              i_mark,      // readiness / aging-clock restart
    input  logic              i_pick,      // this cell's turn in the pick pass
    input  logic              i_age,       // aging and run step
    input  logic [TimeW-1:0]  i_now,
    input  logic [15:0]       i_interval,
    input  logic [SlotW-1:0]  i_best_slot,
    input  t_best             i_tok,
    output t_best             o_tok,
    output logic              o_finish,
    output logic [BurstW-1:0] o_burst,
    output logic [ArrW-1:0]   o_arr,
    output logic              o_pending
);

    logic              r_valid, r_done, r_was;
    logic [ArrW-1:0]   r_arr;
    logic [BurstW-1:0] r_burst, r_left;
    logic [PrioW-1:0]  r_prio;
    logic [TimeW-1:0]  r_mark;
    logic              ready;
    logic              better;
    logic [TimeW:0]    waited;
    logic [TimeW-1:0]  now_inc;

    assign ready = r_valid && !r_done && ({16'd0, r_arr} <= i_now) && (r_left != '0);
    assign now_inc = (i_now == TimeMax) ? i_now : i_now + 32'd1;
    assign waited = (r_mark > i_now) ? '0 : {1'b0, i_now - r_mark} + 33'd1;

    // token compare
    assign better = ready && (!i_tok.found || r_prio < i_tok.prio ||
                    (r_prio == i_tok.prio && r_arr < i_tok.arr));
    always_comb begin
        o_tok = i_tok;
        if (i_pick && better) begin
            o_tok = '{found: 1'b1, prio: r_prio, arr: r_arr, slot: ID};
        end
    end

    assign o_finish  = (i_best_slot == ID) && (r_left == BurstW'(1));
    assign o_burst   = r_burst;
    assign o_arr     = r_arr;
    assign o_pending = r_valid && !r_done;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= 1'b0;
            r_was   <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_done  <= (i_burst == '0);
            r_was   <= 1'b0;
        end else if (i_mark) begin
            r_was <= ready;
        end else if (i_age && ready && i_best_slot == ID && r_left == BurstW'(1)) begin
            r_done <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_arr   <= i_arr;
            r_burst <= i_burst;
            r_left  <= i_burst;
            r_prio  <= i_prio;
            r_mark  <= '0;
        end else if (i_mark) begin
            if (ready && !r_was) r_mark <= i_now;
        end else if (i_age && ready) begin
            if (i_best_slot == ID) begin
                r_left <= r_left - BurstW'(1);
            end else if (waited >= {17'd0, i_interval}) begin
                if (r_prio != '0) r_prio <= r_prio - PrioW'(1);
                r_mark <= now_inc;
            end
        end
    end

endmodule

[rtl/pas_checker.sv]
// ----------------------------------------------------------------------------
// pas_checker: port-level checks of the scheduler
// Watches result framing against the input handshake.
// ----------------------------------------------------------------------------
module pas_checker
    import pas_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_cpu_idle,
    input logic o_job_finished
);

    // an idle tick never reports a completion
    a_idle_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_cpu_idle && o_job_finished)) else $error("idle finish");

    // no input taken while a result waits
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("input open with result pending");

    // stalled result stays
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid) else $error("result dropped");

endmodule

bind priority_aging_scheduler pas_checker u_pas_checker (
    .i_clk, .i_rst_n, .o_stall, .o_valid, .i_stall,
    .o_cpu_idle, .o_job_finished
);
